### rtl/core/tbf_pkg.sv
// Shared constants, arctangent table builder and register codes for the tire force pipeline
`timescale 1ns / 1ps
package tbf_pkg;

   localparam int PIPE_DEPTH = 13;
   localparam int LANES = 2;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPT_TEMP   = 3'd0,
      CSR_TEMP_SENS  = 3'd1,
      CSR_SLIDE_MU   = 3'd2,
      CSR_PEAK_MU    = 3'd3,
      CSR_LONG_STIFF = 3'd4,
      CSR_LAT_STIFF  = 3'd5,
      CSR_RADIUS     = 3'd6
   } csr_reg_type;

   localparam logic signed [13:0] OPT_TEMP_RST = 14'sd1440;
   localparam logic [15:0] TEMP_SENS_RST = 16'd256;
   localparam logic [15:0] SLIDE_MU_RST = 16'd3277;
   localparam logic [15:0] PEAK_MU_RST = 16'd4915;
   localparam logic [19:0] LONG_STIFF_RST = 20'd100000;
   localparam logic [19:0] LAT_STIFF_RST = 20'd80000;
   localparam logic [10:0] RADIUS_RST = 11'd330;

   // slip zones, lane 0 longitudinal, lane 1 lateral
   localparam logic [16:0] DEAD_LIMIT = 17'd17;
   localparam logic [16:0] LIN_MAX [LANES] = '{17'd1638, 17'd819};
   localparam logic [16:0] SLIP_CLAMP [LANES] = '{17'd16384, 17'd8192};
   localparam logic [4:0] SLIP_GAIN [LANES] = '{5'd10, 5'd12};

   // divide by five through reciprocal, exact below 8192
   localparam logic [13:0] DIV5_MUL = 14'd13108;
   // friction loss: divide by 625 after a shift of eight, exact below 2^26
   localparam logic [26:0] RED_MUL = 27'd109951163;
   localparam logic [37:0] RED_BIG = 38'd40960000;
   localparam logic [45:0] RED_HALF = 46'd80000;
   // torque: divide by 390625 after a shift of seven, exact below 2^35
   localparam logic [35:0] TQ_MUL = 36'd46116860185;
   localparam logic [55:0] TQ_HALF = 56'd25000000;
   localparam logic [55:0] TQ_SAT = 56'd4000050000000;
   localparam logic [16:0] TQ_LIMIT = 17'd80000;
   localparam logic [15:0] TQ_MIN_LOAD = 16'd100;
   // rolling resistance: divide by 25
   localparam logic [19:0] RR_MUL = 20'd671089;

   localparam int ATAN_DEPTH = 1024;
   localparam int ATAN_AW = $clog2(ATAN_DEPTH + 1);
   localparam int ATAN_T_W = 17;
   localparam int ATAN_D_W = 9;

   typedef logic [ATAN_D_W+ATAN_T_W-1:0] atan_word_type;
   typedef atan_word_type atan_rom_type [ATAN_DEPTH+1];

   localparam longint CORDIC_ANGLE [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000
   };

   // entry i: (2/pi)*atan(10*i/depth) in Q16, packed with the step to entry i+1
   function automatic atan_rom_type atan_build();
      atan_rom_type rom;
      longint tab [ATAN_DEPTH+1];
      longint x, y, z, dx, dy, step;
      int i, k;
      for (i = 0; i <= ATAN_DEPTH; i++) begin
         x = longint'(ATAN_DEPTH) * 65536;
         y = longint'(10 * i) * 65536;
         z = 0;
         for (k = 0; k < 32; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
               x = x + dx;
               y = y - dy;
               z = z + CORDIC_ANGLE[k];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - CORDIC_ANGLE[k];
            end
         end
         if (z < 0) begin
            z = 0;
         end
         tab[i] = (z + 8192) >>> 14;
      end
      for (i = 0; i <= ATAN_DEPTH; i++) begin
         step = (i < ATAN_DEPTH) ? tab[i+1] - tab[i] : 64'sd0;
         rom[i] = {ATAN_D_W'(step), ATAN_T_W'(tab[i])};
      end
      return rom;
   endfunction

   localparam atan_rom_type ATAN_ROM = atan_build();

endpackage

### rtl/core/tire_brush_force_model.sv
// Top level: pipelined tire force, torque and rolling resistance evaluator
`timescale 1ns / 1ps
// Throughput: one item per cycle unless a stall holds the stages; the arctangent
// table read and the split torque reciprocal multiply each take their own stage.
// A stall on the rsp_ side while rsp_valid is high freezes every stage and
// raises req_stall. Reset clears all stage valid bits and restores every
// configuration register to its default.
module tire_brush_force_model (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_long_slip,
   input  logic signed [15:0]               req_lat_slip,
   input  logic [15:0]                      req_vertical_load,
   input  logic signed [13:0]               req_tire_temperature,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_long_force,
   output logic signed [31:0]               rsp_lat_force,
   output logic signed [17:0]               rsp_align_torque,
   output logic [13:0]                      rsp_rolling_resistance,
   input  logic                             csr_we,
   input  logic [tbf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tbf_pkg::*;

   typedef struct packed {
      logic [15:0]      load;
      logic [LANES-1:0] neg;
      logic [LANES-1:0] dead;
      logic [LANES-1:0] lin;
   } carry_type;

   logic adv;
   logic [PIPE_DEPTH:1] vld_ff, vld_in;
   carry_type car_ff [1:PIPE_DEPTH];
   carry_type car_in;

   logic signed [13:0] opt_temp_ff;
   logic [15:0] temp_sens_ff, slide_mu_ff, peak_mu_ff;
   logic [19:0] long_stiff_ff, lat_stiff_ff;
   logic [10:0] radius_ff;
   logic [19:0] stiff_w [LANES];
   logic signed [15:0] slip_w [LANES];

   // stage 1
   logic [16:0] mag_in [LANES], mag1_ff [LANES], clamp_w [LANES];
   logic [17:0] x_in [LANES], x1_ff [LANES];
   logic signed [14:0] d_in, d1_ff;
   // stage 2
   logic signed [29:0] sq_w;
   logic [28:0] dd2_ff;
   logic [30:0] lin_in [LANES], lin2_ff [LANES];
   logic [26:0] idxp_w [LANES];
   logic [ATAN_AW-1:0] idx2_ff [LANES];
   logic [17:0] x2_ff [LANES];
   // stage 3
   logic [44:0] p_in, p3_ff;
   logic [31:0] lins_w [LANES];
   logic [20:0] linr3_ff [LANES], linr4_ff [LANES], linr5_ff [LANES], linr6_ff [LANES];
   logic [20:0] linr7_ff [LANES], linr8_ff [LANES];
   logic [17:0] i160_w [LANES], rx_w [LANES];
   logic [7:0] r3_ff [LANES];
   atan_word_type rom3_ff [LANES];
   // stage 4
   logic [45:0] n1_w;
   logic [25:0] q4_ff;
   logic big4_ff, big5_ff;
   logic [16:0] v_in [LANES], v4_ff [LANES], t4_ff [LANES];
   // stage 5
   logic [52:0] qm_in, qm5_ff;
   logic [17:0] vr_w [LANES];
   logic [26:0] wp_w [LANES];
   logic [16:0] g5_ff [LANES], g6_ff [LANES], g7_ff [LANES];
   // stage 6
   logic [16:0] red_w;
   logic signed [17:0] diff_w;
   logic [15:0] mu_in, mu6_ff;
   // stage 7
   logic [31:0] ml_in, ml7_ff;
   // stage 8
   logic [48:0] prod_in [LANES], prod8_ff [LANES];
   // stage 9
   logic [49:0] fs_w [LANES];
   logic [25:0] fmag_in [LANES], fmag9_ff [LANES];
   logic [26:0] rl_w;
   logic [28:0] p1_in, p1_9_ff;
   // stage 10
   logic [31:0] fext_w [LANES];
   logic signed [31:0] force_in [LANES], force10_ff [LANES], force11_ff [LANES];
   logic signed [31:0] force12_ff [LANES];
   logic [54:0] p2_in, p2_10_ff;
   logic [18:0] rl6_w;
   logic [38:0] rv_in, rv10_ff;
   // stage 11
   logic [55:0] n2_w;
   logic sat11_ff, sat12_ff;
   logic [34:0] a11_ff;
   logic [13:0] rr11_ff, rr12_ff;
   // stage 12
   logic [52:0] ph_in, ph12_ff;
   logic [53:0] pl_in, pl12_ff;
   // stage 13
   logic [71:0] sum_w;
   logic [16:0] tmag_w;
   logic signed [17:0] tq_in;
   logic signed [31:0] rsp_long_force_ff, rsp_lat_force_ff;
   logic signed [17:0] rsp_align_torque_ff;
   logic [13:0] rsp_rolling_resistance_ff;

   assign adv = !vld_ff[PIPE_DEPTH] || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in = {vld_ff[PIPE_DEPTH-1:1], req_valid};

   assign rsp_valid = vld_ff[PIPE_DEPTH];
   assign rsp_long_force = rsp_long_force_ff;
   assign rsp_lat_force = rsp_lat_force_ff;
   assign rsp_align_torque = rsp_align_torque_ff;
   assign rsp_rolling_resistance = rsp_rolling_resistance_ff;

   assign stiff_w[0] = long_stiff_ff;
   assign stiff_w[1] = lat_stiff_ff;
   assign slip_w[0] = req_long_slip;
   assign slip_w[1] = req_lat_slip;

   always_ff @(posedge clock) begin
      if (reset) begin
         opt_temp_ff <= OPT_TEMP_RST;
         temp_sens_ff <= TEMP_SENS_RST;
         slide_mu_ff <= SLIDE_MU_RST;
         peak_mu_ff <= PEAK_MU_RST;
         long_stiff_ff <= LONG_STIFF_RST;
         lat_stiff_ff <= LAT_STIFF_RST;
         radius_ff <= RADIUS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPT_TEMP:   opt_temp_ff <= csr_wdata[13:0];
            CSR_TEMP_SENS:  temp_sens_ff <= csr_wdata[15:0];
            CSR_SLIDE_MU:   slide_mu_ff <= csr_wdata[15:0];
            CSR_PEAK_MU:    peak_mu_ff <= csr_wdata[15:0];
            CSR_LONG_STIFF: long_stiff_ff <= csr_wdata;
            CSR_LAT_STIFF:  lat_stiff_ff <= csr_wdata;
            CSR_RADIUS:     radius_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      car_in.load = req_vertical_load;
      d_in = {req_tire_temperature[13], req_tire_temperature} - {opt_temp_ff[13], opt_temp_ff};
      for (int l = 0; l < LANES; l++) begin
         car_in.neg[l] = slip_w[l][15];
         mag_in[l] = slip_w[l][15] ? 17'd0 - {slip_w[l][15], slip_w[l]} : {1'b0, slip_w[l]};
         car_in.dead[l] = mag_in[l] < DEAD_LIMIT;
         car_in.lin[l] = mag_in[l] <= LIN_MAX[l];
         clamp_w[l] = (mag_in[l] > SLIP_CLAMP[l]) ? SLIP_CLAMP[l] : mag_in[l];
         x_in[l] = clamp_w[l] * SLIP_GAIN[l];
      end
   end

   always_comb begin
      sq_w = d1_ff * d1_ff;
      p_in = temp_sens_ff * dd2_ff;
      n1_w = 46'(p3_ff) + RED_HALF;
      qm_in = q4_ff * RED_MUL;
      red_w = qm5_ff[52:36];
      diff_w = $signed({2'b00, peak_mu_ff}) - $signed({1'b0, red_w});
      if (big5_ff || diff_w < $signed({2'b00, slide_mu_ff})) begin
         mu_in = slide_mu_ff;
      end else begin
         mu_in = diff_w[15:0];
      end
      ml_in = mu6_ff * car_ff[6].load;
      rl_w = radius_ff * car_ff[8].load;
      p1_in = {rl_w, 1'b0} + 29'(rl_w);
      p2_in = fmag9_ff[1] * p1_9_ff;
      rl6_w = {car_ff[9].load, 2'b00} + {car_ff[9].load, 1'b0} + 19'd12;
      rv_in = rl6_w * RR_MUL;
      n2_w = 56'(p2_10_ff) + TQ_HALF;
      ph_in = a11_ff[34:18] * TQ_MUL;
      pl_in = a11_ff[17:0] * TQ_MUL;
      sum_w = {ph12_ff, 18'd0} + 72'(pl12_ff);
      if (car_ff[12].load < TQ_MIN_LOAD) begin
         tmag_w = '0;
      end else if (sat12_ff) begin
         tmag_w = TQ_LIMIT;
      end else begin
         tmag_w = sum_w[70:54];
      end
      tq_in = car_ff[12].neg[1] ? 18'd0 - {1'b0, tmag_w} : {1'b0, tmag_w};
      for (int l = 0; l < LANES; l++) begin
         lin_in[l] = stiff_w[l] * mag1_ff[l][10:0];
         idxp_w[l] = x1_ff[l][17:5] * DIV5_MUL;
         lins_w[l] = 32'(lin2_ff[l]) + 32'd512;
         i160_w[l] = {idx2_ff[l], 7'd0} + {idx2_ff[l], 5'd0};
         rx_w[l] = x2_ff[l] - i160_w[l];
         v_in[l] = rom3_ff[l][ATAN_D_W+ATAN_T_W-1:ATAN_T_W] * r3_ff[l];
         vr_w[l] = 18'(v4_ff[l]) + 18'd80;
         wp_w[l] = vr_w[l][17:5] * DIV5_MUL;
         prod_in[l] = ml7_ff * g7_ff[l];
         fs_w[l] = 50'(prod8_ff[l]) + (50'd1 << 23);
         if (car_ff[8].dead[l]) begin
            fmag_in[l] = '0;
         end else if (car_ff[8].lin[l]) begin
            fmag_in[l] = 26'(linr8_ff[l]);
         end else begin
            fmag_in[l] = fs_w[l][49:24];
         end
         fext_w[l] = {6'd0, fmag9_ff[l]};
         force_in[l] = car_ff[9].neg[l] ? 32'd0 - fext_w[l] : fext_w[l];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[1] <= car_in;
         for (int k = 2; k <= PIPE_DEPTH; k++) begin
            car_ff[k] <= car_ff[k-1];
         end
         d1_ff <= d_in;
         dd2_ff <= sq_w[28:0];
         p3_ff <= p_in;
         q4_ff <= n1_w[33:8];
         big4_ff <= n1_w[45:8] >= RED_BIG;
         qm5_ff <= qm_in;
         big5_ff <= big4_ff;
         mu6_ff <= mu_in;
         ml7_ff <= ml_in;
         p1_9_ff <= p1_in;
         p2_10_ff <= p2_in;
         rv10_ff <= rv_in;
         sat11_ff <= n2_w >= TQ_SAT;
         a11_ff <= n2_w[41:7];
         rr11_ff <= rv10_ff[37:24];
         ph12_ff <= ph_in;
         pl12_ff <= pl_in;
         sat12_ff <= sat11_ff;
         rr12_ff <= rr11_ff;
         for (int l = 0; l < LANES; l++) begin
            mag1_ff[l] <= mag_in[l];
            x1_ff[l] <= x_in[l];
            lin2_ff[l] <= lin_in[l];
            idx2_ff[l] <= idxp_w[l][26:16];
            x2_ff[l] <= x1_ff[l];
            linr3_ff[l] <= lins_w[l][30:10];
            r3_ff[l] <= rx_w[l][7:0];
            rom3_ff[l] <= ATAN_ROM[idx2_ff[l]];
            v4_ff[l] <= v_in[l];
            t4_ff[l] <= rom3_ff[l][ATAN_T_W-1:0];
            linr4_ff[l] <= linr3_ff[l];
            g5_ff[l] <= t4_ff[l] + 17'(wp_w[l][26:16]);
            linr5_ff[l] <= linr4_ff[l];
            g6_ff[l] <= g5_ff[l];
            linr6_ff[l] <= linr5_ff[l];
            g7_ff[l] <= g6_ff[l];
            linr7_ff[l] <= linr6_ff[l];
            prod8_ff[l] <= prod_in[l];
            linr8_ff[l] <= linr7_ff[l];
            fmag9_ff[l] <= fmag_in[l];
            force10_ff[l] <= force_in[l];
            force11_ff[l] <= force10_ff[l];
            force12_ff[l] <= force11_ff[l];
         end
         rsp_long_force_ff <= force12_ff[0];
         rsp_lat_force_ff <= force12_ff[1];
         rsp_align_torque_ff <= tq_in;
         rsp_rolling_resistance_ff <= rr12_ff;
      end
   end

endmodule

### rtl/core/tbf_checker.sv
// Port-level checker for the tire force pipeline and its bind
`timescale 1ns / 1ps
module tbf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [31:0]               rsp_lat_force,
   input logic signed [17:0]               rsp_align_torque,
   input logic [13:0]                      rsp_rolling_resistance
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input held off without a blocked result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_lat_force)
         && $stable(rsp_align_torque)))
      else $error("blocked result changed");

   a_torque_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_align_torque <= 18'sd80000 && rsp_align_torque >= -18'sd80000))
      else $error("torque beyond limit");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rolling_resistance <= 14'd15729))
      else $error("rolling resistance out of range");

endmodule

bind tire_brush_force_model tbf_checker u_tbf_checker (.*);

### test/tb_top.sv
// Self-checking testbench for the tire force pipeline: directed, random, stall and register sweep tests
`timescale 1ns / 1ps
module tb_top;
   import tbf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic signed [31:0] long_force;
      logic signed [31:0] lat_force;
      logic signed [17:0] align_torque;
      logic [13:0]        rolling_resistance;
   } wheel_force_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_long_slip = '0;
   logic signed [15:0] req_lat_slip = '0;
   logic [15:0] req_vertical_load = '0;
   logic signed [13:0] req_tire_temperature = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_long_force;
   logic signed [31:0] rsp_lat_force;
   logic signed [17:0] rsp_align_torque;
   logic [13:0] rsp_rolling_resistance;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the register file
   logic signed [13:0] opt_temp;
   logic [15:0] temp_sens, slide_mu, peak_mu;
   logic [19:0] long_stiff, lat_stiff;
   logic [10:0] radius;

   longint atan_q16 [ATAN_DEPTH+1];
   wheel_force_type force_q [$];
   int errors = 0;
   int idle_cnt = 0;
   int long_hold = 0;
   int rx_wait = 0;
   bit jitter_on = 1'b1;

   tire_brush_force_model uut (.*);

   always #2 clock = ~clock;

   function automatic void build_atan_table();
      longint x, y, z, dx, dy;
      for (int i = 0; i <= ATAN_DEPTH; i++) begin
         x = longint'(ATAN_DEPTH) * 65536;
         y = longint'(10 * i) * 65536;
         z = 0;
         for (int k = 0; k < 32; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
               x += dx; y -= dy; z += CORDIC_ANGLE[k];
            end else begin
               x -= dx; y += dy; z -= CORDIC_ANGLE[k];
            end
         end
         if (z < 0) z = 0;
         atan_q16[i] = (z + 8192) >>> 14;
      end
   endfunction

   function automatic longint atan_interp(longint xq14);
      longint num, idx, frac;
      num = xq14 * ATAN_DEPTH;
      idx = num / 163840;
      frac = num % 163840;
      if (idx >= ATAN_DEPTH) return atan_q16[ATAN_DEPTH];
      return atan_q16[idx] + ((atan_q16[idx+1] - atan_q16[idx]) * frac + 81920) / 163840;
   endfunction

   function automatic longint slip_force(logic signed [15:0] slip, longint stiff,
                                         longint lin_mul, longint clamp, longint gain,
                                         longint load, longint mu);
      longint mag, f, c;
      mag = (slip < 0) ? -longint'(slip) : longint'(slip);
      if (mag * 1000 < 16384) return 0;
      if (mag * lin_mul < 16384) f = (stiff * mag + 512) >>> 10;
      else begin
         c = (mag > clamp) ? clamp : mag;
         f = (mu * load * atan_interp(gain * c) + (64'sd1 << 23)) >>> 24;
      end
      if (slip < 0) f = -f;
      if (f > 64'sd2147483647) f = 64'sd2147483647;
      if (f < -64'sd2147483648) f = -64'sd2147483648;
      return f;
   endfunction

   function automatic wheel_force_type predict_wheel_forces(logic signed [15:0] ls,
         logic signed [15:0] lt, logic [15:0] load, logic signed [13:0] temp);
      wheel_force_type r;
      longint d, red, mu, fx, fy, fm, t;
      d = longint'(temp) - longint'(opt_temp);
      red = (longint'(temp_sens) * d * d + 80000) / 160000;
      mu = longint'(peak_mu) - red;
      if (mu < longint'(slide_mu)) mu = slide_mu;
      fx = slip_force(ls, long_stiff, 10, 16384, 10, load, mu);
      fy = slip_force(lt, lat_stiff, 20, 8192, 12, load, mu);
      t = 0;
      if (load >= 100) begin
         fm = (fy < 0) ? -fy : fy;
         t = (fm * longint'(radius) * longint'(load) * 3 + 25000000) / 50000000;
         if (t > 80000) t = 80000;
         if (fy < 0) t = -t;
      end
      r.long_force = fx[31:0];
      r.lat_force = fy[31:0];
      r.align_torque = t[17:0];
      r.rolling_resistance = 14'((longint'(load) * 6 + 12) / 25);
      return r;
   endfunction

   function automatic void reset_regs();
      opt_temp = OPT_TEMP_RST; temp_sens = TEMP_SENS_RST; slide_mu = SLIDE_MU_RST;
      peak_mu = PEAK_MU_RST; long_stiff = LONG_STIFF_RST; lat_stiff = LAT_STIFF_RST;
      radius = RADIUS_RST;
   endfunction

   // result checker
   always @(posedge clock) begin
      wheel_force_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (force_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: result with no transfer pending");
         end else begin
            e = force_q.pop_front();
            if (e.long_force !== rsp_long_force || e.lat_force !== rsp_lat_force ||
                e.align_torque !== rsp_align_torque ||
                e.rolling_resistance !== rsp_rolling_resistance) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                           e.long_force, e.lat_force, e.align_torque,
                           e.rolling_resistance, rsp_long_force, rsp_lat_force,
                           rsp_align_torque, rsp_rolling_resistance);
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold <= long_hold - 1;
      end else if (rx_wait > 0) begin
         rsp_stall <= 1'b1;
         rx_wait <= rx_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (jitter_on && rsp_valid && !rsp_stall) rx_wait <= $urandom_range(0, 3);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cnt <= 0;
      else if (req_valid || force_q.size() > 0) idle_cnt <= idle_cnt + 1;
      if (idle_cnt > STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_wheel_item(logic signed [15:0] ls, logic signed [15:0] lt,
                                  logic [15:0] load, logic signed [13:0] temp);
      int gap;
      gap = jitter_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_long_slip <= ls;
      req_lat_slip <= lt;
      req_vertical_load <= load;
      req_tire_temperature <= temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      force_q.push_back(predict_wheel_forces(ls, lt, load, temp));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (force_q.size() > 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OPT_TEMP:   opt_temp = val[13:0];
         CSR_TEMP_SENS:  temp_sens = val[15:0];
         CSR_SLIDE_MU:   slide_mu = val[15:0];
         CSR_PEAK_MU:    peak_mu = val[15:0];
         CSR_LONG_STIFF: long_stiff = val[19:0];
         CSR_LAT_STIFF:  lat_stiff = val[19:0];
         CSR_RADIUS:     radius = val[10:0];
         default: ;
      endcase
   endtask

   task automatic write_unused_reg();
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_slip();
      int m;
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: m = $urandom_range(0, 17);
         2, 3: m = $urandom_range(16, 1700);
         default: m = $urandom_range(800, 32768);
      endcase
      return 16'($urandom_range(0, 1) ? -m : m);
   endfunction

   function automatic logic signed [13:0] rand_temp();
      if ($urandom_range(0, 3) == 0) return 14'($urandom);
      return 14'(int'($urandom_range(0, 5600)) - 800);
   endfunction

   task automatic test_directed();
      logic signed [15:0] slips [12] = '{16'sd0, 16'sd1, -16'sd16, 16'sd17, -16'sd17,
                                         16'sd818, 16'sd819, 16'sd1637, -16'sd1638,
                                         16'sd8192, 16'sd32767, 16'sh8000};
      for (int i = 0; i < 12; i++)
         send_wheel_item(slips[i], slips[11-i], 16'(i * 5000 + 99), 14'sd1440);
      send_wheel_item(16'sd4000, -16'sd4000, 16'd0, 14'sh2000);
      send_wheel_item(16'sh8000, 16'sh8000, 16'd65535, 14'sd8191);
      send_wheel_item(16'sd32767, 16'sd32767, 16'd100, 14'sd4800);
      send_wheel_item(16'sd20000, 16'sd2000, 16'd99, -14'sd800);
      send_wheel_item(-16'sd1, 16'sd1, 16'd65535, 14'sd0);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++)
         send_wheel_item(rand_slip(), rand_slip(), 16'($urandom), rand_temp());
   endtask

   task automatic test_config_sweep();
      write_reg(CSR_OPT_TEMP, 20'(-14'sd800));
      write_reg(CSR_TEMP_SENS, 20'd65535);
      write_reg(CSR_SLIDE_MU, 20'd0);
      write_reg(CSR_PEAK_MU, 20'd65535);
      write_reg(CSR_LONG_STIFF, 20'hFFFFF);
      write_reg(CSR_LAT_STIFF, 20'hFFFFF);
      write_reg(CSR_RADIUS, 20'd2047);
      test_random(300);
      write_reg(CSR_OPT_TEMP, 20'd4800);
      write_reg(CSR_TEMP_SENS, 20'd0);
      write_reg(CSR_SLIDE_MU, 20'd65535);
      write_reg(CSR_LONG_STIFF, 20'd0);
      write_reg(CSR_LAT_STIFF, 20'd0);
      write_reg(CSR_RADIUS, 20'd0);
      write_unused_reg();
      test_random(200);
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_OPT_TEMP, 20'($urandom));
         write_reg(CSR_TEMP_SENS, 20'($urandom));
         write_reg(CSR_SLIDE_MU, 20'($urandom_range(0, 8000)));
         write_reg(CSR_PEAK_MU, 20'($urandom));
         write_reg(CSR_LONG_STIFF, 20'($urandom));
         write_reg(CSR_LAT_STIFF, 20'($urandom));
         write_reg(CSR_RADIUS, 20'($urandom));
         test_random(200);
      end
   endtask

   task automatic test_backpressure();
      jitter_on = 1'b0;
      long_hold = 80;
      test_random(60);
      drain();
      test_random(200);
      jitter_on = 1'b1;
   endtask

   initial begin
      build_atan_table();
      reset_regs();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400);
      test_backpressure();
      test_config_sweep();
      drain();
      repeat (PIPE_DEPTH + 5) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
